// ----- hdl/wsfr_pkg.sv -----
`timescale 1ns / 1ps

package wsfr_pkg;

  // Width of the kept-byte counter; matches the capacity register and message_bytes.
  localparam int CNT_W = 24;

  localparam logic [2:0] KIND_BYTE  = 3'd0;
  localparam logic [2:0] KIND_END   = 3'd1;
  localparam logic [2:0] KIND_PONG  = 3'd2;
  localparam logic [2:0] KIND_CLOSE = 3'd3;
  localparam logic [2:0] KIND_EMPTY = 3'd4;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       data;
    logic             eom;
    logic [CNT_W-1:0] msg_bytes;
    logic             ovf;
  } res_t;

endpackage

// ----- hdl/wsfr_parser.sv -----
`timescale 1ns / 1ps

module wsfr_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [7:0]                  rx_byte,
  input  logic [wsfr_pkg::CNT_W-1:0]  limit,
  output logic                        res_valid,
  output wsfr_pkg::res_t              res
);

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_MASK = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  logic [2:0]                 phase_r, phase_nxt;
  logic [2:0]                 hcnt_r, hcnt_nxt;
  logic                       fin_r, fin_nxt;
  logic [3:0]                 op_r, op_nxt;
  logic                       masked_r, masked_nxt;
  logic [63:0]                rem_r, rem_nxt;
  logic [31:0]                key_r, key_nxt;
  logic [1:0]                 pos_r, pos_nxt;
  logic [wsfr_pkg::CNT_W-1:0] kept_r, kept_nxt;
  logic                       drop_r, drop_nxt;

  logic       len_known;
  logic       frame_start;
  logic       last;
  logic       eom;
  logic [7:0] key_byte;
  logic [7:0] data_byte;

  always_comb begin
    phase_nxt   = phase_r;
    hcnt_nxt    = hcnt_r;
    fin_nxt     = fin_r;
    op_nxt      = op_r;
    masked_nxt  = masked_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    kept_nxt    = kept_r;
    drop_nxt    = drop_r;
    len_known   = 1'b0;
    frame_start = 1'b0;
    last        = 1'b0;
    eom         = 1'b0;
    res_valid   = 1'b0;
    res         = '0;

    case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
    data_byte = masked_r ? (rx_byte ^ key_byte) : rx_byte;

    case (phase_r)
      PH_HDR0: begin
        fin_nxt   = rx_byte[7];
        op_nxt    = rx_byte[3:0];
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        masked_nxt = rx_byte[7];
        rem_nxt    = '0;
        if (rx_byte[6:0] == wsfr_pkg::LEN_EXT16) begin
          phase_nxt = PH_EXT;
          hcnt_nxt  = 3'd1;
        end else if (rx_byte[6:0] == wsfr_pkg::LEN_EXT64) begin
          phase_nxt = PH_EXT;
          hcnt_nxt  = 3'd7;
        end else begin
          rem_nxt   = {57'd0, rx_byte[6:0]};
          len_known = 1'b1;
        end
      end
      PH_EXT: begin
        rem_nxt = {rem_r[55:0], rx_byte};
        if (hcnt_r != 3'd0) begin
          hcnt_nxt = hcnt_r - 3'd1;
        end else begin
          len_known = 1'b1;
        end
      end
      PH_MASK: begin
        key_nxt = {key_r[23:0], rx_byte};
        if (hcnt_r != 3'd0) begin
          hcnt_nxt = hcnt_r - 3'd1;
        end else begin
          frame_start = 1'b1;
        end
      end
      PH_DATA: begin
        pos_nxt = pos_r + 2'd1;
        if (rem_r != 64'd0) begin
          rem_nxt = rem_r - 64'd1;
        end
        last = (rem_nxt == 64'd0);
        eom  = last && fin_r;
        if (kept_r < limit) begin
          kept_nxt      = kept_r + {{(wsfr_pkg::CNT_W-1){1'b0}}, 1'b1};
          res_valid     = 1'b1;
          res.kind      = wsfr_pkg::KIND_BYTE;
          res.data      = data_byte;
          res.eom       = eom;
          res.msg_bytes = kept_nxt;
          res.ovf       = drop_r;
        end else begin
          drop_nxt = 1'b1;
          if (eom) begin
            res_valid     = 1'b1;
            res.kind      = wsfr_pkg::KIND_END;
            res.eom       = 1'b1;
            res.msg_bytes = kept_r;
            res.ovf       = 1'b1;
          end
        end
        if (eom) begin
          kept_nxt = '0;
          drop_nxt = 1'b0;
        end
        if (last) begin
          phase_nxt = PH_HDR0;
        end
      end
      PH_SKIP: begin
        if (rem_r != 64'd0) begin
          rem_nxt = rem_r - 64'd1;
        end
        if (rem_nxt == 64'd0) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        phase_nxt = PH_HDR0;
      end
    endcase

    // length complete: collect the mask key, or start the frame right away
    if (len_known) begin
      key_nxt = '0;
      if (masked_nxt) begin
        phase_nxt = PH_MASK;
        hcnt_nxt  = 3'd3;
      end else begin
        frame_start = 1'b1;
      end
    end

    if (frame_start) begin
      pos_nxt = '0;
      if (op_r == wsfr_pkg::OP_CLOSE) begin
        res_valid     = 1'b1;
        res.kind      = wsfr_pkg::KIND_CLOSE;
        res.msg_bytes = kept_r;
        res.ovf       = drop_r;
        kept_nxt      = '0;
        drop_nxt      = 1'b0;
        phase_nxt     = (rem_nxt != 64'd0) ? PH_SKIP : PH_HDR0;
      end else if (op_r == wsfr_pkg::OP_PING || op_r == wsfr_pkg::OP_PONG) begin
        phase_nxt = (rem_nxt != 64'd0) ? PH_SKIP : PH_HDR0;
        if (op_r == wsfr_pkg::OP_PING) begin
          res_valid     = 1'b1;
          res.kind      = wsfr_pkg::KIND_PONG;
          res.msg_bytes = kept_r;
          res.ovf       = drop_r;
        end
      end else if (rem_nxt != 64'd0) begin
        phase_nxt = PH_DATA;
      end else begin
        phase_nxt = PH_HDR0;
        if (fin_r) begin
          // zero-length final frame closes the message
          res_valid     = 1'b1;
          res.kind      = (kept_r == '0 && !drop_r) ? wsfr_pkg::KIND_EMPTY
                                                    : wsfr_pkg::KIND_END;
          res.eom       = 1'b1;
          res.msg_bytes = kept_r;
          res.ovf       = drop_r;
          kept_nxt      = '0;
          drop_nxt      = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      hcnt_r   <= '0;
      fin_r    <= 1'b0;
      op_r     <= '0;
      masked_r <= 1'b0;
      rem_r    <= '0;
      key_r    <= '0;
      pos_r    <= '0;
      kept_r   <= '0;
      drop_r   <= 1'b0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      fin_r    <= fin_nxt;
      op_r     <= op_nxt;
      masked_r <= masked_nxt;
      rem_r    <= rem_nxt;
      key_r    <= key_nxt;
      pos_r    <= pos_nxt;
      kept_r   <= kept_nxt;
      drop_r   <= drop_nxt;
    end
  end

endmodule

// ----- hdl/websocket_frame_receiver.sv -----
`timescale 1ns / 1ps
// Each accepted byte waits in the input register, and any result it yields is
// held in the result register.
// Throughput: one byte per cycle; the input register drains whenever the result
// register is empty or being taken, so only out_stall slows intake.
// Reset (rst_n low, synchronous): parser waits for a header, counters clear,
// capacity returns to 4194303, both registers empty.
module websocket_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data,
  output logic        out_end_of_message,
  output logic [23:0] out_message_bytes,
  output logic        out_overflowed,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  localparam logic [23:0] CAP_RESET = 24'd4194303;

  logic [23:0]    cap_r;
  logic           in_v_r;
  logic [7:0]     in_b_r;
  logic           out_v_r, out_v_nxt;
  wsfr_pkg::res_t out_r;
  logic           advance;
  logic           res_valid;
  wsfr_pkg::res_t res;

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;

  wsfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .rx_byte   (in_b_r),
    .limit     (cap_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = res_valid;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_b_r <= in_rx_byte;
    end
    if (advance && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_kind           = out_r.kind;
  assign out_data           = out_r.data;
  assign out_end_of_message = out_r.eom;
  assign out_message_bytes  = out_r.msg_bytes;
  assign out_overflowed     = out_r.ovf;

  a_data_only_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != wsfr_pkg::KIND_BYTE |-> out_data == 8'd0)
    else $error("nonzero data on a non-byte result");

  a_empty_msg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == wsfr_pkg::KIND_EMPTY
    |-> out_message_bytes == 24'd0 && !out_overflowed && out_end_of_message)
    else $error("empty-message result with kept or dropped bytes");

  a_byte_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == wsfr_pkg::KIND_BYTE |-> out_message_bytes != 24'd0)
    else $error("payload byte delivered with zero kept count");

  a_ctrl_no_eom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == wsfr_pkg::KIND_PONG || out_kind == wsfr_pkg::KIND_CLOSE)
    |-> !out_end_of_message)
    else $error("control result marked as message end");

endmodule
